// File: sv/cpu8_alu_flag_execute_defines.svh
// Assertion macros shared by the 8-bit ALU execute block.
`ifndef CPU8_ALU_FLAG_EXECUTE_DEFINES_SVH
`define CPU8_ALU_FLAG_EXECUTE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define C8ALU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c8alu assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define C8ALU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c8alu assertion failed");
`else
`define C8ALU_ASSERT_IMP(lbl, ante, cons)
`define C8ALU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: sv/c8alu_pkg.sv
// Types, opcode fields and flag helpers for the 8-bit ALU execute block.
package c8alu_pkg;

  // Status bit positions: N V 1 B D I Z C
  localparam int unsigned FB_C = 0;
  localparam int unsigned FB_Z = 1;
  localparam int unsigned FB_I = 2;
  localparam int unsigned FB_D = 3;
  localparam int unsigned FB_B = 4;
  localparam int unsigned FB_5 = 5;
  localparam int unsigned FB_V = 6;
  localparam int unsigned FB_N = 7;

  // Opcode layout aaa bbb cc: group field cc
  localparam logic [1:0] GRP_CTL = 2'b00;
  localparam logic [1:0] GRP_ALU = 2'b01;
  localparam logic [1:0] GRP_RMW = 2'b10;

  // Operation field aaa per group
  localparam logic [2:0] AAA_AND = 3'b001;
  localparam logic [2:0] AAA_ADC = 3'b011;
  localparam logic [2:0] AAA_CMP = 3'b110;
  localparam logic [2:0] AAA_ASL = 3'b000;
  localparam logic [2:0] AAA_DEC = 3'b110;
  localparam logic [2:0] AAA_BIT = 3'b001;
  localparam logic [2:0] AAA_CPY = 3'b110;
  localparam logic [2:0] AAA_CPX = 3'b111;

  // Addressing field bbb for the control group
  localparam logic [2:0] BBB_IMM = 3'b000;
  localparam logic [2:0] BBB_ZP  = 3'b001;
  localparam logic [2:0] BBB_ABS = 3'b011;

  // Branches all end in 1 0000; bits 7:6 pick the flag, bit 5 the sense
  localparam logic [4:0] BR_LOW = 5'b10000;
  localparam logic [1:0] BR_N   = 2'd0;
  localparam logic [1:0] BR_V   = 2'd1;
  localparam logic [1:0] BR_C   = 2'd2;
  localparam logic [1:0] BR_Z   = 2'd3;

  // Single-form opcodes
  localparam logic [7:0] OPC_ASL_A = 8'h0A;
  localparam logic [7:0] OPC_DEX   = 8'hCA;
  localparam logic [7:0] OPC_DEY   = 8'h88;
  localparam logic [7:0] OPC_CLC   = 8'h18;
  localparam logic [7:0] OPC_CLD   = 8'hD8;
  localparam logic [7:0] OPC_CLI   = 8'h58;
  localparam logic [7:0] OPC_CLV   = 8'hB8;

  typedef enum logic [3:0] {
    OP_ADC, OP_AND, OP_ASL_A, OP_ASL_M, OP_BIT, OP_BRANCH, OP_CLEAR,
    OP_CMP, OP_CPX, OP_CPY, OP_DEC_M, OP_DEX, OP_DEY, OP_BAD
  } op_class_t;

  typedef struct packed {
    op_class_t  op;
    logic [7:0] clr_mask;
    logic [1:0] br_sel;
    logic       br_sense;
  } dec_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] p;
  } arch_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] p;
    logic [7:0] wdata;
    logic       we;
    logic       br;
    logic       bad;
  } result_t;

  // Replace N and Z from an 8-bit result and set the always-one bit.
  function automatic logic [7:0] put_nz(logic [7:0] p, logic [7:0] r);
    logic [7:0] f;
    f       = p;
    f[FB_Z] = (r == 8'h00);
    f[FB_N] = r[7];
    f[FB_5] = 1'b1;
    return f;
  endfunction

endpackage

// File: sv/c8alu_if.sv
// Request and result channel interfaces of the 8-bit ALU execute block.
interface c8alu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [7:0] operand;

  modport source (output valid, output opcode, output operand, input ready);
  modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface c8alu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] acc_value;
  logic [7:0] x_value;
  logic [7:0] y_value;
  logic [7:0] status_flags;
  logic [7:0] write_data;
  logic       write_enable;
  logic       branch_taken;
  logic       unhandled;

  modport source (output valid, output acc_value, output x_value, output y_value,
                  output status_flags, output write_data, output write_enable,
                  output branch_taken, output unhandled, input ready);
  modport sink   (input valid, input acc_value, input x_value, input y_value,
                  input status_flags, input write_data, input write_enable,
                  input branch_taken, input unhandled, output ready);
endinterface

// File: sv/cpu8_alu_flag_execute.sv
// Top level of the 8-bit ALU and status flag execute block.
// Each request carries one opcode and its already fetched operand byte; the
// block runs it against its own A, X, Y and status registers (all zero after
// reset) and returns one result with the registers after the instruction,
// the memory write-back byte and enable (ASL and DEC on memory), whether a
// conditional branch would be taken, and an unhandled flag for opcodes
// outside the covered set or ADC with the decimal flag set, which change
// nothing. A request is taken every cycle unless the result side stalls: it
// is held in the input register, is decoded and executed in a single pass
// that also updates the architectural registers, and lands in the result
// register; throughput is one request per cycle while results drain. The
// execute step of one request finishes before the next one reads the
// registers, so back-to-back dependent instructions see each other's
// results. Status bit 5 is set by any instruction that writes N and Z;
// compare carry means no borrow.
`include "cpu8_alu_flag_execute_defines.svh"

module cpu8_alu_flag_execute (
  input  logic         clk,
  input  logic         rst_n,
  c8alu_in_if.sink     in_ch,
  c8alu_out_if.source  out_ch
);
  import c8alu_pkg::*;

  // input register
  logic       s1_v_r;
  logic [7:0] s1_op_r;
  logic [7:0] s1_opnd_r;

  // architectural registers and result register
  arch_t      arch_r;
  arch_t      arch_nxt;
  logic       out_v_r;
  result_t    res_r;
  result_t    res_nxt;

  dec_t       dec;

  logic       out_adv;
  logic       s1_fire;
  logic       in_rdy;
  logic       in_fire;

  // Advance the result register whenever it is empty or being drained.
  assign out_adv = !out_v_r || out_ch.ready;
  // Execute the held request when it can move into the result register.
  assign s1_fire = s1_v_r && out_adv;
  assign in_rdy  = !s1_v_r || out_adv;
  assign in_fire = in_ch.valid && in_rdy;

  assign in_ch.ready = in_rdy;

  c8alu_dec u_dec (
    .opcode (s1_op_r),
    .dec    (dec)
  );

  c8alu_exu u_exu (
    .dec     (dec),
    .operand (s1_opnd_r),
    .st      (arch_r),
    .st_nxt  (arch_nxt),
    .res     (res_nxt)
  );

  // Control state and the programmer-visible registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      arch_r  <= '0;
    end else begin
      if (in_rdy) begin
        s1_v_r <= in_ch.valid;
      end
      if (out_adv) begin
        out_v_r <= s1_v_r;
      end
      // commit only when the request really executes
      if (s1_fire) begin
        arch_r <= arch_nxt;
      end
    end
  end

  // Payload registers: hold while stalled.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_ch.opcode;
      s1_opnd_r <= in_ch.operand;
    end
    if (s1_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.acc_value    = res_r.a;
  assign out_ch.x_value      = res_r.x;
  assign out_ch.y_value      = res_r.y;
  assign out_ch.status_flags = res_r.p;
  assign out_ch.write_data   = res_r.wdata;
  assign out_ch.write_enable = res_r.we;
  assign out_ch.branch_taken = res_r.br;
  assign out_ch.unhandled    = res_r.bad;

  // An unhandled request never writes memory or reports a branch.
  `C8ALU_ASSERT_IMP(a_bad_no_side_effect, out_v_r && res_r.bad, !res_r.we && !res_r.br && (res_r.wdata == 8'h00))
  // Registers move only when a request executes.
  `C8ALU_ASSERT_NXT(a_state_hold_idle, !s1_fire, $stable(arch_r))
  // An unhandled request leaves the registers as they were.
  `C8ALU_ASSERT_NXT(a_bad_keeps_state, s1_fire && res_nxt.bad, $stable(arch_r))
  // A result appears only after a request left the input register.
  `C8ALU_ASSERT_IMP(a_result_from_stage, $rose(out_v_r), $past(s1_fire))

endmodule

// File: sv/c8alu_dec.sv
// Opcode decoder: sorts an opcode byte into an operation class.
module c8alu_dec (
  input  logic [7:0]        opcode,
  output c8alu_pkg::dec_t   dec
);
  import c8alu_pkg::*;

  logic [2:0] aaa;
  logic [2:0] bbb;
  logic [1:0] cc;

  assign aaa = opcode[7:5];
  assign bbb = opcode[4:2];
  assign cc  = opcode[1:0];

  always_comb begin
    dec.op       = OP_BAD;
    dec.clr_mask = 8'h00;
    dec.br_sel   = opcode[7:6];
    dec.br_sense = opcode[5];
    if (cc == GRP_ALU) begin
      // every addressing form of the ALU group is covered
      if (aaa == AAA_AND) begin
        dec.op = OP_AND;
      end else if (aaa == AAA_ADC) begin
        dec.op = OP_ADC;
      end else if (aaa == AAA_CMP) begin
        dec.op = OP_CMP;
      end
    end else if (cc == GRP_RMW) begin
      if (opcode == OPC_ASL_A) begin
        dec.op = OP_ASL_A;
      end else if (opcode == OPC_DEX) begin
        dec.op = OP_DEX;
      end else if (aaa == AAA_ASL && opcode[2]) begin
        dec.op = OP_ASL_M;
      end else if (aaa == AAA_DEC && opcode[2]) begin
        dec.op = OP_DEC_M;
      end
    end else if (cc == GRP_CTL) begin
      if (opcode[4:0] == BR_LOW) begin
        dec.op = OP_BRANCH;
      end else if (opcode == OPC_DEY) begin
        dec.op = OP_DEY;
      end else if (opcode == OPC_CLC) begin
        dec.op = OP_CLEAR;
        dec.clr_mask[FB_C] = 1'b1;
      end else if (opcode == OPC_CLD) begin
        dec.op = OP_CLEAR;
        dec.clr_mask[FB_D] = 1'b1;
      end else if (opcode == OPC_CLI) begin
        dec.op = OP_CLEAR;
        dec.clr_mask[FB_I] = 1'b1;
      end else if (opcode == OPC_CLV) begin
        dec.op = OP_CLEAR;
        dec.clr_mask[FB_V] = 1'b1;
      end else if (aaa == AAA_BIT && (bbb == BBB_ZP || bbb == BBB_ABS)) begin
        dec.op = OP_BIT;
      end else if (aaa == AAA_CPY &&
                   (bbb == BBB_IMM || bbb == BBB_ZP || bbb == BBB_ABS)) begin
        dec.op = OP_CPY;
      end else if (aaa == AAA_CPX &&
                   (bbb == BBB_IMM || bbb == BBB_ZP || bbb == BBB_ABS)) begin
        dec.op = OP_CPX;
      end
    end
  end

endmodule

// File: sv/c8alu_exu.sv
// Execute logic: one add, logic, shift, decrement or compare step and its flag update, or a branch test or flag clear.
module c8alu_exu (
  input  c8alu_pkg::dec_t    dec,
  input  logic [7:0]         operand,
  input  c8alu_pkg::arch_t   st,
  output c8alu_pkg::arch_t   st_nxt,
  output c8alu_pkg::result_t res
);
  import c8alu_pkg::*;

  logic [8:0] sum;
  logic [8:0] diff;
  logic [7:0] cmp_reg;
  logic [7:0] r;
  logic       flag;

  assign sum  = {1'b0, st.a} + {1'b0, operand} + {8'h00, st.p[FB_C]};

  always_comb begin
    unique case (dec.op)
      OP_CPX:  cmp_reg = st.x;
      OP_CPY:  cmp_reg = st.y;
      default: cmp_reg = st.a;
    endcase
  end

  // carry out of the subtract is the inverted borrow
  assign diff = {1'b0, cmp_reg} - {1'b0, operand};

  always_comb begin
    unique case (dec.br_sel)
      BR_N:    flag = st.p[FB_N];
      BR_V:    flag = st.p[FB_V];
      BR_C:    flag = st.p[FB_C];
      default: flag = st.p[FB_Z];
    endcase
  end

  always_comb begin
    st_nxt    = st;
    r         = 8'h00;
    res.wdata = 8'h00;
    res.we    = 1'b0;
    res.br    = 1'b0;
    res.bad   = 1'b0;
    unique case (dec.op)
      OP_ADC: begin
        if (st.p[FB_D]) begin
          // decimal mode not supported: leave state alone
          res.bad = 1'b1;
        end else begin
          r              = sum[7:0];
          st_nxt.a       = r;
          st_nxt.p       = put_nz(st.p, r);
          st_nxt.p[FB_C] = sum[8];
          st_nxt.p[FB_V] = ~(st.a[7] ^ operand[7]) & (st.a[7] ^ r[7]);
        end
      end
      OP_AND: begin
        r        = st.a & operand;
        st_nxt.a = r;
        st_nxt.p = put_nz(st.p, r);
      end
      OP_ASL_A: begin
        r              = {st.a[6:0], 1'b0};
        st_nxt.a       = r;
        st_nxt.p       = put_nz(st.p, r);
        st_nxt.p[FB_C] = st.a[7];
      end
      OP_ASL_M: begin
        r              = {operand[6:0], 1'b0};
        res.wdata      = r;
        res.we         = 1'b1;
        st_nxt.p       = put_nz(st.p, r);
        st_nxt.p[FB_C] = operand[7];
      end
      OP_BIT: begin
        r              = st.a & operand;
        st_nxt.p       = put_nz(st.p, r);
        st_nxt.p[FB_N] = operand[7];
        st_nxt.p[FB_V] = operand[6];
      end
      OP_BRANCH: begin
        res.br = (flag == dec.br_sense);
      end
      OP_CLEAR: begin
        st_nxt.p = st.p & ~dec.clr_mask;
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        r              = diff[7:0];
        st_nxt.p       = put_nz(st.p, r);
        st_nxt.p[FB_C] = ~diff[8];
      end
      OP_DEC_M: begin
        r         = operand - 8'd1;
        res.wdata = r;
        res.we    = 1'b1;
        st_nxt.p  = put_nz(st.p, r);
      end
      OP_DEX: begin
        r        = st.x - 8'd1;
        st_nxt.x = r;
        st_nxt.p = put_nz(st.p, r);
      end
      OP_DEY: begin
        r        = st.y - 8'd1;
        st_nxt.y = r;
        st_nxt.p = put_nz(st.p, r);
      end
      default: begin
        res.bad = 1'b1;
      end
    endcase
    res.a = st_nxt.a;
    res.x = st_nxt.x;
    res.y = st_nxt.y;
    res.p = st_nxt.p;
  end

endmodule
